// File: design/grdc_pkg.sv
// Shared types, register codes, constants and sequencer states of the grid ray caster.
package grdc_pkg;

   typedef struct packed {
      logic        kind;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        cell_wall;
      logic [11:0] column;
   } req_type;

   typedef struct packed {
      logic [5:0] hit_x;
      logic [5:0] hit_y;
      logic       hit_side;
      logic       escaped;
   } rsp_type;

   typedef struct packed {
      logic [21:0]        pos_x;
      logic [21:0]        pos_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
      logic [12:0]        screen_width;
   } cfg_type;

   typedef struct packed {
      logic        is_cast;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        cell_wall;
      logic [11:0] column;
   } qent_type;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CAST  = 1'b1;

   localparam logic [2:0] REG_POS_X        = 3'd0;
   localparam logic [2:0] REG_POS_Y        = 3'd1;
   localparam logic [2:0] REG_DIR_X        = 3'd2;
   localparam logic [2:0] REG_DIR_Y        = 3'd3;
   localparam logic [2:0] REG_PLANE_X      = 3'd4;
   localparam logic [2:0] REG_PLANE_Y      = 3'd5;
   localparam logic [2:0] REG_SCREEN_WIDTH = 3'd6;

   localparam logic [21:0]        RST_POS_X   = 22'd2097152;
   localparam logic [21:0]        RST_POS_Y   = 22'd2097152;
   localparam logic signed [15:0] RST_DIR_X   = 16'sd16384;
   localparam logic signed [15:0] RST_DIR_Y   = 16'sd0;
   localparam logic signed [15:0] RST_PLANE_X = 16'sd0;
   localparam logic signed [15:0] RST_PLANE_Y = 16'sd10813;
   localparam logic [12:0]        RST_WIDTH   = 13'd640;

   localparam int DIV_BITS = 46;
   localparam logic [45:0] DELTA_SAT = 46'h100_0000_0000;
   localparam logic [49:0] SIDE_SAT  = 50'h1_0000_0000_0000;
   localparam logic [59:0] SQRT_TOP  = 60'h400_0000_0000_0000;
   localparam logic signed [28:0] ONE_Q14 = 29'sd16384;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_CAM,
      ST_MUL_RX,
      ST_MUL_RY,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_SUM,
      ST_SQRT,
      ST_DIV_DX,
      ST_DIV_DY,
      ST_SIDE_XL,
      ST_SIDE_XH,
      ST_SIDE_YL,
      ST_SIDE_YH,
      ST_SIDE_YD,
      ST_STEP,
      ST_TEST,
      ST_FINISH
   } state_type;

endpackage

// File: design/grdc_front.sv
// Front end: accepts request beats, drops off-grid writes, feeds the work queue.
module grdc_front #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  grdc_pkg::req_type  req_data,
   input  logic               init_done,
   input  logic               q_full,
   output logic               q_push,
   output grdc_pkg::qent_type q_data
);

   logic accept;
   logic keep;

   always_comb begin
      req_ready = init_done && !q_full;
      accept    = req_valid && req_ready;
      keep      = (req_data.kind == grdc_pkg::KIND_CAST) ||
                  ((int'(req_data.cell_x) < GRID_COLS) && (int'(req_data.cell_y) < GRID_ROWS));
      q_push    = accept && keep;
      q_data.is_cast   = (req_data.kind == grdc_pkg::KIND_CAST);
      q_data.cell_x    = req_data.cell_x;
      q_data.cell_y    = req_data.cell_y;
      q_data.cell_wall = req_data.cell_wall;
      q_data.column    = req_data.column;
   end

endmodule

// File: design/grdc_queue.sv
// Short work queue between the front end and the ray walker.
module grdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  grdc_pkg::qent_type push_data,
   input  logic               pop,
   output logic               valid,
   output logic               full,
   output grdc_pkg::qent_type head
);

   grdc_pkg::qent_type         mem_ff [grdc_pkg::QDEPTH];
   logic [grdc_pkg::QAW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [grdc_pkg::QAW:0]     cnt_ff, cnt_in;

   always_comb begin
      valid  = (cnt_ff != '0);
      full   = (cnt_ff == (grdc_pkg::QAW+1)'(grdc_pkg::QDEPTH));
      head   = mem_ff[rp_ff];
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (grdc_pkg::QAW+1)'(push) - (grdc_pkg::QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

// File: design/grdc_walk.sv
// Back end: wall map, ray setup sequencer (divider, multiplier, root) and DDA walk.
module grdc_walk #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64,
   parameter int MAX_STEPS = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  grdc_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  grdc_pkg::qent_type q_head,
   output logic               q_pop,
   output logic               init_done,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output grdc_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XBW   = $clog2(GRID_COLS);
   localparam int YBW   = $clog2(GRID_ROWS);
   localparam int MBW   = (XBW > YBW) ? XBW : YBW;
   localparam int CW    = ((MBW > 6) ? MBW : 6) + 2;
   localparam int NW    = $clog2(MAX_STEPS + 1);

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
      addr_of = AW'(y) * AW'(GRID_COLS) + AW'(x);
   endfunction

   logic mem [DEPTH];
   logic rd_ff;
   logic          mem_we, mem_wd, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;

   grdc_pkg::state_type state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [45:0]          dvd_ff, dvd_in;
   logic [29:0]          dvs_ff, dvs_in, rem_ff, rem_in;
   logic [5:0]           dcnt_ff, dcnt_in;
   logic signed [61:0]   mul_ff, mul_in;
   logic signed [30:0]   mul_a, mul_b;
   logic signed [28:0]   cam_ff, cam_in;
   logic signed [29:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [59:0]          sqv_ff, sqv_in, sqr_ff, sqr_in, bit_ff, bit_in;
   logic [29:0]          len_ff, len_in;
   logic [40:0]          dlx_ff, dlx_in, dly_ff, dly_in;
   logic [37:0]          lo_ff, lo_in;
   logic [48:0]          sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic [CW-1:0]        mx_ff, mx_in, my_ff, my_in;
   logic                 side_ff, side_in, inb_ff, inb_in;
   logic [NW-1:0]        n_ff, n_in;
   grdc_pkg::rsp_type    res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [30:0] div_r, div_diff;
   logic        div_ge, div_last;
   logic [29:0] div_rem;
   logic [45:0] div_q;
   logic [40:0] div_sat;
   logic [59:0] sq_t;
   logic [12:0] width;
   logic [29:0] abs_rx, abs_ry;
   logic [16:0] frac_x, frac_y;
   logic [57:0] side_full;
   logic [49:0] sum_x, sum_y;
   logic [CW-1:0] nx, ny, tx, ty;
   logic        step_x, inb;
   logic [CW-1:0] cols_c, rows_c;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      cam_in       = cam_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      sqv_in       = sqv_ff;
      sqr_in       = sqr_ff;
      bit_in       = bit_ff;
      len_in       = len_ff;
      dlx_in       = dlx_ff;
      dly_in       = dly_ff;
      lo_in        = lo_ff;
      sdx_in       = sdx_ff;
      sdy_in       = sdy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      side_in      = side_ff;
      inb_in       = inb_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = '0;
      mul_b        = '0;
      mem_we       = 1'b0;
      mem_wd       = 1'b0;
      mem_wa       = '0;
      mem_re       = 1'b0;
      mem_ra       = '0;
      q_pop        = 1'b0;

      cols_c = CW'(GRID_COLS);
      rows_c = CW'(GRID_ROWS);
      width  = (cfg.screen_width == '0) ? 13'd1 : cfg.screen_width;
      abs_rx = rx_ff[29] ? 30'(-rx_ff) : 30'(rx_ff);
      abs_ry = ry_ff[29] ? 30'(-ry_ff) : 30'(ry_ff);
      frac_x = rx_ff[29] ? {1'b0, cfg.pos_x[15:0]} : grdc_pkg::ONE_Q16 - {1'b0, cfg.pos_x[15:0]};
      frac_y = ry_ff[29] ? {1'b0, cfg.pos_y[15:0]} : grdc_pkg::ONE_Q16 - {1'b0, cfg.pos_y[15:0]};
      side_full = {mul_ff[36:0], 21'b0} + {20'b0, lo_ff};

      // restoring divider, one quotient bit a cycle; quotient shifts into dvd
      div_r    = {rem_ff, dvd_ff[45]};
      div_diff = div_r - {1'b0, dvs_ff};
      div_ge   = (div_r >= {1'b0, dvs_ff});
      div_rem  = div_ge ? div_diff[29:0] : div_r[29:0];
      div_q    = {dvd_ff[44:0], div_ge};
      div_last = (dcnt_ff == 6'(grdc_pkg::DIV_BITS - 1));
      // a zero divisor yields all ones and saturates here as well
      div_sat  = (div_q > grdc_pkg::DELTA_SAT) ? grdc_pkg::DELTA_SAT[40:0] : div_q[40:0];

      sq_t = sqr_ff + bit_ff;

      step_x = (sdx_ff < sdy_ff);
      nx     = rx_ff[29] ? mx_ff - CW'(1) : mx_ff + CW'(1);
      ny     = ry_ff[29] ? my_ff - CW'(1) : my_ff + CW'(1);
      tx     = step_x ? nx : mx_ff;
      ty     = step_x ? my_ff : ny;
      inb    = !tx[CW-1] && (tx < cols_c) && !ty[CW-1] && (ty < rows_c);
      sum_x  = {1'b0, sdx_ff} + {9'b0, dlx_ff};
      sum_y  = {1'b0, sdy_ff} + {9'b0, dly_ff};

      unique case (state_ff)
         grdc_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = grdc_pkg::ST_IDLE;
            end
         end
         grdc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_head.is_cast) begin
                  mem_we = 1'b1;
                  mem_wd = q_head.cell_wall;
                  mem_wa = addr_of(CW'(q_head.cell_x), CW'(q_head.cell_y));
               end else if ((CW'(cfg.pos_x[21:16]) >= cols_c) ||
                            (CW'(cfg.pos_y[21:16]) >= rows_c)) begin
                  res_in   = '{hit_x: '0, hit_y: '0, hit_side: 1'b0, escaped: 1'b1};
                  state_in = grdc_pkg::ST_FINISH;
               end else begin
                  dvd_in   = {19'b0, q_head.column, 15'b0};
                  dvs_in   = {17'b0, width};
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = grdc_pkg::ST_DIV_CAM;
               end
            end
         end
         grdc_pkg::ST_DIV_CAM: begin
            dvd_in  = div_q;
            rem_in  = div_rem;
            dcnt_in = dcnt_ff + 1'b1;
            if (div_last) begin
               state_in = grdc_pkg::ST_MUL_RX;
            end
         end
         grdc_pkg::ST_MUL_RX: begin
            cam_in   = $signed(dvd_ff[28:0]) - grdc_pkg::ONE_Q14;
            mul_a    = 31'(cfg.plane_x);
            mul_b    = 31'(cam_in);
            state_in = grdc_pkg::ST_MUL_RY;
         end
         grdc_pkg::ST_MUL_RY: begin
            mul_a    = 31'(cfg.plane_y);
            mul_b    = 31'(cam_ff);
            rx_in    = 30'(cfg.dir_x) + 30'(mul_ff >>> 14);
            state_in = grdc_pkg::ST_SQ_X;
         end
         grdc_pkg::ST_SQ_X: begin
            mul_a    = 31'(rx_ff);
            mul_b    = 31'(rx_ff);
            ry_in    = 30'(cfg.dir_y) + 30'(mul_ff >>> 14);
            state_in = grdc_pkg::ST_SQ_Y;
         end
         grdc_pkg::ST_SQ_Y: begin
            mul_a    = 31'(ry_ff);
            mul_b    = 31'(ry_ff);
            sqv_in   = mul_ff[59:0];
            state_in = grdc_pkg::ST_SQ_SUM;
         end
         grdc_pkg::ST_SQ_SUM: begin
            sqv_in   = sqv_ff + mul_ff[59:0];
            sqr_in   = '0;
            bit_in   = grdc_pkg::SQRT_TOP;
            state_in = grdc_pkg::ST_SQRT;
         end
         grdc_pkg::ST_SQRT: begin
            if (bit_ff == '0) begin
               len_in   = sqr_ff[29:0];
               dvd_in   = {sqr_ff[29:0], 16'b0};
               dvs_in   = abs_rx;
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = grdc_pkg::ST_DIV_DX;
            end else begin
               if (sqv_ff >= sq_t) begin
                  sqv_in = sqv_ff - sq_t;
                  sqr_in = (sqr_ff >> 1) + bit_ff;
               end else begin
                  sqr_in = sqr_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         grdc_pkg::ST_DIV_DX: begin
            dvd_in  = div_q;
            rem_in  = div_rem;
            dcnt_in = dcnt_ff + 1'b1;
            if (div_last) begin
               dlx_in   = div_sat;
               dvd_in   = {len_ff, 16'b0};
               dvs_in   = abs_ry;
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = grdc_pkg::ST_DIV_DY;
            end
         end
         grdc_pkg::ST_DIV_DY: begin
            dvd_in  = div_q;
            rem_in  = div_rem;
            dcnt_in = dcnt_ff + 1'b1;
            if (div_last) begin
               dly_in   = div_sat;
               state_in = grdc_pkg::ST_SIDE_XL;
            end
         end
         grdc_pkg::ST_SIDE_XL: begin
            mul_a    = $signed({14'b0, frac_x});
            mul_b    = $signed({10'b0, dlx_ff[20:0]});
            state_in = grdc_pkg::ST_SIDE_XH;
         end
         grdc_pkg::ST_SIDE_XH: begin
            mul_a    = $signed({14'b0, frac_x});
            mul_b    = $signed({11'b0, dlx_ff[40:21]});
            lo_in    = mul_ff[37:0];
            state_in = grdc_pkg::ST_SIDE_YL;
         end
         grdc_pkg::ST_SIDE_YL: begin
            sdx_in   = {8'b0, side_full[56:16]};
            mul_a    = $signed({14'b0, frac_y});
            mul_b    = $signed({10'b0, dly_ff[20:0]});
            state_in = grdc_pkg::ST_SIDE_YH;
         end
         grdc_pkg::ST_SIDE_YH: begin
            mul_a    = $signed({14'b0, frac_y});
            mul_b    = $signed({11'b0, dly_ff[40:21]});
            lo_in    = mul_ff[37:0];
            state_in = grdc_pkg::ST_SIDE_YD;
         end
         grdc_pkg::ST_SIDE_YD: begin
            sdy_in   = {8'b0, side_full[56:16]};
            mx_in    = CW'(cfg.pos_x[21:16]);
            my_in    = CW'(cfg.pos_y[21:16]);
            n_in     = '0;
            state_in = grdc_pkg::ST_STEP;
         end
         grdc_pkg::ST_STEP: begin
            if (step_x) begin
               sdx_in  = (sum_x > grdc_pkg::SIDE_SAT) ? grdc_pkg::SIDE_SAT[48:0] : sum_x[48:0];
               mx_in   = nx;
               side_in = 1'b0;
            end else begin
               sdy_in  = (sum_y > grdc_pkg::SIDE_SAT) ? grdc_pkg::SIDE_SAT[48:0] : sum_y[48:0];
               my_in   = ny;
               side_in = 1'b1;
            end
            inb_in   = inb;
            mem_re   = inb;
            mem_ra   = addr_of(tx, ty);
            n_in     = n_ff + 1'b1;
            state_in = grdc_pkg::ST_TEST;
         end
         grdc_pkg::ST_TEST: begin
            priority if (!inb_ff) begin
               res_in   = '{hit_x: '0, hit_y: '0, hit_side: 1'b0, escaped: 1'b1};
               state_in = grdc_pkg::ST_FINISH;
            end else if (rd_ff) begin
               res_in   = '{hit_x: mx_ff[5:0], hit_y: my_ff[5:0], hit_side: side_ff,
                            escaped: 1'b0};
               state_in = grdc_pkg::ST_FINISH;
            end else if (n_ff == NW'(MAX_STEPS)) begin
               res_in   = '{hit_x: '0, hit_y: '0, hit_side: 1'b0, escaped: 1'b1};
               state_in = grdc_pkg::ST_FINISH;
            end else begin
               state_in = grdc_pkg::ST_STEP;
            end
         end
         grdc_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = grdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grdc_pkg::ST_IDLE;
         end
      endcase

      mul_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grdc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      mul_ff      <= mul_in;
      cam_ff      <= cam_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      sqv_ff      <= sqv_in;
      sqr_ff      <= sqr_in;
      bit_ff      <= bit_in;
      len_ff      <= len_in;
      dlx_ff      <= dlx_in;
      dly_ff      <= dly_in;
      lo_ff       <= lo_in;
      sdx_ff      <= sdx_in;
      sdy_ff      <= sdy_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      side_ff     <= side_in;
      inb_ff      <= inb_in;
      n_ff        <= n_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   assign init_done = (state_ff != grdc_pkg::ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/grid_ray_dda_caster.sv
// Grid ray caster top level: register port, front end, work queue and ray walker.
// After reset the block sweeps the wall map clear, one cell a cycle, and takes no request
// until that is done; register writes are taken throughout. A map write is done in the
// walker's idle state. A cast makes three passes through the shared 46-bit bit-serial divider
// (camera x and both delta distances), runs a square root and uses the shared multiplier,
// then for each cell stepped (at most MAX_STEPS) does a map read and its test.
// Requests queue up to four deep ahead of the walker, and a finished result waits in an
// output register, so neither side stalls the other while there is room.
module grid_ray_dda_caster #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64,
   parameter int MAX_STEPS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grdc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grdc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   grdc_pkg::cfg_type  cfg_ff, cfg_in;
   grdc_pkg::qent_type q_in_data, q_head;
   logic               q_push, q_pop, q_valid, q_full, init_done;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   always_comb begin
      pready  = 1'b1;
      csr_wr  = psel && penable && pwrite;
      csr_idx = paddr[4:2];
      cfg_in  = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            grdc_pkg::REG_POS_X:        cfg_in.pos_x        = pwdata[21:0];
            grdc_pkg::REG_POS_Y:        cfg_in.pos_y        = pwdata[21:0];
            grdc_pkg::REG_DIR_X:        cfg_in.dir_x        = $signed(pwdata[15:0]);
            grdc_pkg::REG_DIR_Y:        cfg_in.dir_y        = $signed(pwdata[15:0]);
            grdc_pkg::REG_PLANE_X:      cfg_in.plane_x      = $signed(pwdata[15:0]);
            grdc_pkg::REG_PLANE_Y:      cfg_in.plane_y      = $signed(pwdata[15:0]);
            grdc_pkg::REG_SCREEN_WIDTH: cfg_in.screen_width = pwdata[12:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
      unique case (csr_idx)
         grdc_pkg::REG_POS_X:        prdata = {10'b0, cfg_ff.pos_x};
         grdc_pkg::REG_POS_Y:        prdata = {10'b0, cfg_ff.pos_y};
         grdc_pkg::REG_DIR_X:        prdata = 32'(cfg_ff.dir_x);
         grdc_pkg::REG_DIR_Y:        prdata = 32'(cfg_ff.dir_y);
         grdc_pkg::REG_PLANE_X:      prdata = 32'(cfg_ff.plane_x);
         grdc_pkg::REG_PLANE_Y:      prdata = 32'(cfg_ff.plane_y);
         grdc_pkg::REG_SCREEN_WIDTH: prdata = {19'b0, cfg_ff.screen_width};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x        <= grdc_pkg::RST_POS_X;
         cfg_ff.pos_y        <= grdc_pkg::RST_POS_Y;
         cfg_ff.dir_x        <= grdc_pkg::RST_DIR_X;
         cfg_ff.dir_y        <= grdc_pkg::RST_DIR_Y;
         cfg_ff.plane_x      <= grdc_pkg::RST_PLANE_X;
         cfg_ff.plane_y      <= grdc_pkg::RST_PLANE_Y;
         cfg_ff.screen_width <= grdc_pkg::RST_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grdc_front #(
      .GRID_COLS(GRID_COLS),
      .GRID_ROWS(GRID_ROWS)
   ) u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .init_done(init_done),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   grdc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_data),
      .pop      (q_pop),
      .valid    (q_valid),
      .full     (q_full),
      .head     (q_head)
   );

   grdc_walk #(
      .GRID_COLS(GRID_COLS),
      .GRID_ROWS(GRID_ROWS),
      .MAX_STEPS(MAX_STEPS)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .init_done(init_done),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   a_escape_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.escaped |->
         rsp_data.hit_x == '0 && rsp_data.hit_y == '0 && !rsp_data.hit_side)
      else $error("escaped result carries hit fields");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && init_done)
      else $error("queue pop while empty or clearing");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !q_valid && !rsp_valid)
      else $error("work pending during map clear");

endmodule

// File: test/grdc_checker.sv
// Ray caster checker: tracks registers and wall map, predicts each cast and compares results.
module grdc_checker #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64,
   parameter int MAX_STEPS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  grdc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  grdc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                errors,
   output int                pending,
   output int                cast_count,
   output int                hit_count,
   output int                escape_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned DSAT = 64'd1 << 40;
   localparam longint unsigned SSAT = 64'd1 << 48;

   logic [21:0]        view_px, view_py;
   logic signed [15:0] view_dx, view_dy, view_plx, view_ply;
   logic [12:0]        view_width;
   bit                 wall_bits [0:GRID_COLS*GRID_ROWS-1];
   grdc_pkg::rsp_type  hit_queue [$];

   assign pending = hit_queue.size();

   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned delta_for(longint unsigned len, longint comp);
      longint unsigned mag, d;
      mag = (comp < 0) ? longint'(-comp) : longint'(comp);
      if (mag == 0) return DSAT;
      d = (len << 16) / mag;
      return (d > DSAT) ? DSAT : d;
   endfunction

   function automatic longint unsigned side_add(longint unsigned a, longint unsigned b);
      return (a + b > SSAT) ? SSAT : a + b;
   endfunction

   function automatic grdc_pkg::rsp_type trace_ray(logic [11:0] column);
      longint unsigned w, num, len, dlx, dly, sdx, sdy, fx, fy;
      longint cam, rx, ry;
      int mx, my, sx, sy, side;
      grdc_pkg::rsp_type r;
      r = '{hit_x: 6'd0, hit_y: 6'd0, hit_side: 1'b0, escaped: 1'b1};
      w = (view_width == 0) ? 64'd1 : 64'(view_width);
      num = 64'd2 * column * 64'd16384;
      cam = longint'(num / w) - 16384;
      rx = longint'(view_dx) + ((longint'(view_plx) * cam) >>> 14);
      ry = longint'(view_dy) + ((longint'(view_ply) * cam) >>> 14);
      len = root_of(longint'(rx * rx) + longint'(ry * ry));
      dlx = delta_for(len, rx);
      dly = delta_for(len, ry);
      mx = int'(view_px[21:16]);
      my = int'(view_py[21:16]);
      fx = 64'(view_px[15:0]);
      fy = 64'(view_py[15:0]);
      if (mx >= GRID_COLS || my >= GRID_ROWS) return r;
      if (rx < 0) begin
         sx = -1; sdx = (fx * dlx) >> 16;
      end else begin
         sx = 1; sdx = ((64'd65536 - fx) * dlx) >> 16;
      end
      if (ry < 0) begin
         sy = -1; sdy = (fy * dly) >> 16;
      end else begin
         sy = 1; sdy = ((64'd65536 - fy) * dly) >> 16;
      end
      for (int n = 0; n < MAX_STEPS; n++) begin
         if (sdx < sdy) begin
            sdx = side_add(sdx, dlx); mx += sx; side = 0;
         end else begin
            sdy = side_add(sdy, dly); my += sy; side = 1;
         end
         if (mx < 0 || my < 0 || mx >= GRID_COLS || my >= GRID_ROWS) return r;
         if (wall_bits[my*GRID_COLS + mx]) begin
            r.hit_x = mx[5:0];
            r.hit_y = my[5:0];
            r.hit_side = side[0];
            r.escaped = 1'b0;
            return r;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      grdc_pkg::rsp_type want;
      if (reset) begin
         view_px <= grdc_pkg::RST_POS_X;
         view_py <= grdc_pkg::RST_POS_Y;
         view_dx <= grdc_pkg::RST_DIR_X;
         view_dy <= grdc_pkg::RST_DIR_Y;
         view_plx <= grdc_pkg::RST_PLANE_X;
         view_ply <= grdc_pkg::RST_PLANE_Y;
         view_width <= grdc_pkg::RST_WIDTH;
         foreach (wall_bits[i]) wall_bits[i] = 1'b0;
         hit_queue.delete();
         errors <= 0;
         cast_count <= 0;
         hit_count <= 0;
         escape_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               grdc_pkg::REG_POS_X:        view_px <= pwdata[21:0];
               grdc_pkg::REG_POS_Y:        view_py <= pwdata[21:0];
               grdc_pkg::REG_DIR_X:        view_dx <= pwdata[15:0];
               grdc_pkg::REG_DIR_Y:        view_dy <= pwdata[15:0];
               grdc_pkg::REG_PLANE_X:      view_plx <= pwdata[15:0];
               grdc_pkg::REG_PLANE_Y:      view_ply <= pwdata[15:0];
               grdc_pkg::REG_SCREEN_WIDTH: view_width <= pwdata[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.kind == grdc_pkg::KIND_CAST) begin
               hit_queue.push_back(trace_ray(req_data.column));
            end else if (req_data.cell_x < GRID_COLS && req_data.cell_y < GRID_ROWS) begin
               wall_bits[req_data.cell_y*GRID_COLS + req_data.cell_x] = req_data.cell_wall;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = hit_queue.pop_front();
               cast_count <= cast_count + 1;
               if (want.escaped) escape_count <= escape_count + 1;
               else hit_count <= hit_count + 1;
               if (rsp_data.hit_x !== want.hit_x || rsp_data.hit_y !== want.hit_y ||
                   rsp_data.hit_side !== want.hit_side || rsp_data.escaped !== want.escaped) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, want, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

// File: test/tb_grid_ray_dda_caster.sv
// Testbench top for the grid ray caster: clock, reset, stimulus, register setup and verdict.
module tb_grid_ray_dda_caster;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 3000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   grdc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   grdc_pkg::rsp_type rsp_data;
   logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;
   int                errors, pending, cast_count, hit_count, escape_count;
   int                burst_left = 0;
   int                rcv_count = 0;
   int                hold_left = 0;
   logic              park_rsp = 1'b0, park_seen = 1'b0;

   grid_ray_dda_caster dut (.*);

   grdc_checker check (.*);

   initial forever #2 clock = ~clock;

   // receiver: mode follows bits 9:8 of the cycle counter; one long hold when parking is requested
   always @(posedge clock) begin
      rcv_count <= rcv_count + 1;
      park_seen <= park_rsp;
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (park_rsp && !park_seen) begin
         rsp_ready <= 1'b0;
         hold_left <= 4000;
      end else begin
         case (rcv_count[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= (rcv_count[1:0] == 2'd0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   function automatic grdc_pkg::req_type map_beat(int x, int y, bit wall);
      grdc_pkg::req_type r;
      r = '0;
      r.kind = grdc_pkg::KIND_WRITE;
      r.cell_x = 6'(x);
      r.cell_y = 6'(y);
      r.cell_wall = wall;
      r.column = 12'($urandom);
      return r;
   endfunction

   function automatic grdc_pkg::req_type cast_beat(int column);
      grdc_pkg::req_type r;
      r = '0;
      r.cell_x = 6'($urandom);
      r.cell_y = 6'($urandom);
      r.cell_wall = 1'($urandom);
      r.kind = grdc_pkg::KIND_CAST;
      r.column = 12'(column);
      return r;
   endfunction

   task automatic send(grdc_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_view(logic [21:0] px, logic [21:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] plx, logic [15:0] ply,
                            logic [12:0] width);
      // wait out trailing map writes still in the walker
      drain();
      repeat (300) @(posedge clock);
      write_reg(grdc_pkg::REG_POS_X, {10'd0, px});
      write_reg(grdc_pkg::REG_POS_Y, {10'd0, py});
      write_reg(grdc_pkg::REG_DIR_X, {{16{dx[15]}}, dx});
      write_reg(grdc_pkg::REG_DIR_Y, {{16{dy[15]}}, dy});
      write_reg(grdc_pkg::REG_PLANE_X, {{16{plx[15]}}, plx});
      write_reg(grdc_pkg::REG_PLANE_Y, {{16{ply[15]}}, ply});
      write_reg(grdc_pkg::REG_SCREEN_WIDTH, {19'd0, width});
   endtask

   initial begin
      int width;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset view, walls ahead, the starting cell, wall removal
      send(cast_beat(0));
      send(cast_beat(4095));
      send(map_beat(40, 32, 1));
      send(cast_beat(320));
      send(map_beat(32, 32, 1));
      send(cast_beat(320));
      send(map_beat(40, 32, 0));
      send(cast_beat(320));
      send(map_beat(0, 0, 1));
      send(map_beat(63, 63, 1));
      send(map_beat(63, 0, 1));
      send(map_beat(0, 63, 1));
      send(map_beat(32, 40, 1));
      load_view(22'd0, 22'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 13'd0);
      send(cast_beat(0));
      send(cast_beat(4095));
      load_view(22'h3fffff, 22'h3fffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 13'd1);
      send(cast_beat(0));
      send(cast_beat(1));
      load_view(22'h200000, 22'h208000, 16'd0, 16'd16384, 16'd10813, 16'd0, 13'd8191);
      send(cast_beat(4095));
      send(cast_beat(2048));
      load_view(22'h208000, 22'h200000, 16'd0, 16'd0, 16'd0, 16'd0, 13'd4096);
      send(cast_beat(100));

      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 2)
            load_view(22'($urandom), 22'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 13'($urandom));
         else
            load_view(22'($urandom), 22'($urandom),
                      16'($urandom_range(0, 32767) - 16384),
                      16'($urandom_range(0, 32767) - 16384),
                      16'($urandom_range(0, 32767) - 16384),
                      16'($urandom_range(0, 32767) - 16384),
                      13'($urandom_range(1, 4096)));
         width = int'(check.view_width);
         if (phase == 3) park_rsp <= 1'b1;
         for (int k = 0; k < 150; k++) begin
            if (phase == 5 && k == 75) drain();
            if ($urandom_range(0, 99) < 35)
               send(map_beat($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 3) != 0));
            else if ($urandom_range(0, 9) < 8)
               send(cast_beat($urandom_range(0, (width == 0) ? 1 : width)));
            else
               send(cast_beat($urandom_range(0, 4095)));
         end
      end

      drain();
      repeat (600) @(posedge clock);
      $display("Covered %0d casts (%0d wall hits, %0d escapes) over 15 view settings,",
               cast_count, hit_count, escape_count);
      $display("with map writes, bursty input and receiver stalls including one long hold.");
      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// File: files.f
design/grdc_pkg.sv
design/grdc_front.sv
design/grdc_queue.sv
design/grdc_walk.sv
design/grid_ray_dda_caster.sv
test/grdc_checker.sv
test/tb_grid_ray_dda_caster.sv
